// ===== rtl/blas_level1_vector_unit_top_assert.svh =====
// ----------------------------------------------------------------------------
// blas level-1 vector unit assertion macros
// concurrent assertion helpers used by the controller rtl file
// ----------------------------------------------------------------------------
`ifndef BLAS_LEVEL1_VECTOR_UNIT_TOP_ASSERT_SVH
`define BLAS_LEVEL1_VECTOR_UNIT_TOP_ASSERT_SVH

// same-cycle implication
`define BL1_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BL1_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/blas_l1_pkg.sv =====
// ----------------------------------------------------------------------------
// blas_l1_pkg
// shared constants, codes and controller interface types
// ----------------------------------------------------------------------------
package blas_l1_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 2;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_DOT       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DOT_ALPHA = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ABS_SUM   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NORM      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AXPY      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROTATE    = 3'd5;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_ALPHA   = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROT_COS = 2'd2;
    localparam logic [IDX_W-1:0] REG_ROT_SIN = 2'd3;

    localparam logic signed [DATA_W-1:0] SCALE       = DATA_W'(1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] ALPHA_RST   = SCALE;
    localparam logic signed [DATA_W-1:0] ROT_COS_RST = SCALE;
    localparam logic signed [DATA_W-1:0] ROT_SIN_RST = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_FIN,
        S_SQRT,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic fin;
        logic sqrt_start;
        logic root_load;
        logic push;
        logic phase;
    } ctrl_cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic              last;
        logic [MODE_W-1:0] mode;
        logic              sqrt_busy;
        logic              out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/blas_level1_vector_unit_top.sv =====
// sequence: an item is taken only in idle, then multiplied and added; a last reduction
// item passes finish and, for norm, the one-bit-per-cycle square root, then output
// axpy: a multiply-add pass, then output; rotate: a pass per output, then output,
// the two cross products of each output sharing one multiplier pair
// reset: mode dot, alpha and cos one, sin zero, accumulator and sticky flag cleared
// ----------------------------------------------------------------------------
// blas_level1_vector_unit_top
// fixed-point level-1 vector unit: dot, abs sum, norm, axpy, plane rotation
// ----------------------------------------------------------------------------
module blas_level1_vector_unit_top
    import blas_l1_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]   cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,   // x_value, y_value
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [127:0]        m_axis_tdata,   // x_out, y_out, sum_out
    output logic [1:0]          m_axis_tuser    // is_reduction, saturated
);

    ctrl_cmd_t                 cmd;
    ctrl_sts_t                 sts;
    logic                      in_ready;
    logic signed [DATA_W-1:0]  x_out, y_out;
    logic signed [ACC_W-1:0]   sum_out;
    logic                      is_reduction, saturated;

    blas_l1_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    blas_l1_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .x_value      (s_axis_tdata[31:0]),
        .y_value      (s_axis_tdata[63:32]),
        .last         (s_axis_tlast),
        .in_valid     (s_axis_tvalid),
        .out_ready    (m_axis_tready),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_axis_tvalid),
        .x_out        (x_out),
        .y_out        (y_out),
        .sum_out      (sum_out),
        .is_reduction (is_reduction),
        .saturated    (saturated)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = {sum_out, y_out, x_out};
    assign m_axis_tuser  = {saturated, is_reduction};

endmodule

// ===== rtl/blas_l1_isqrt.sv =====
// ----------------------------------------------------------------------------
// blas_l1_isqrt
// floor integer square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module blas_l1_isqrt
    import blas_l1_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACC_W-1:0]    operand,
    output logic                busy,
    output logic [DATA_W-1:0]   root
);

    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] res_reg, res_next;
    logic [ACC_W-1:0] bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic [ACC_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = operand;
            res_next  = '0;
            bit_next  = ACC_W'(1) << (ACC_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == ACC_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[DATA_W-1:0];

endmodule

// ===== rtl/blas_l1_dp.sv =====
// ----------------------------------------------------------------------------
// blas_l1_dp
// datapath: config registers, multipliers, accumulator, result register
// ----------------------------------------------------------------------------
module blas_l1_dp
    import blas_l1_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [DATA_W-1:0]         cfg_data,
    input  logic signed [DATA_W-1:0]  x_value,
    input  logic signed [DATA_W-1:0]  y_value,
    input  logic                      last,
    input  logic                      in_valid,
    input  logic                      out_ready,
    input  ctrl_cmd_t                 cmd,
    output ctrl_sts_t                 sts,
    output logic                      out_valid,
    output logic signed [DATA_W-1:0]  x_out,
    output logic signed [DATA_W-1:0]  y_out,
    output logic signed [ACC_W-1:0]   sum_out,
    output logic                      is_reduction,
    output logic                      saturated
);

    logic [MODE_W-1:0]         mode_reg;
    logic signed [DATA_W-1:0]  alpha_reg, cos_reg, sin_reg;
    logic signed [DATA_W-1:0]  x_reg, y_reg;
    logic                      last_reg;
    logic signed [ACC_W-1:0]   prod_a_reg, prod_b_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      sticky_reg;
    logic signed [DATA_W-1:0]  xo_reg, yo_reg;
    logic signed [ACC_W-1:0]   sum_reg;
    logic                      sat_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  xo_out_reg, yo_out_reg;
    logic signed [ACC_W-1:0]   sum_out_reg;
    logic                      red_out_reg, sat_out_reg;

    logic signed [DATA_W-1:0]  a1, a2, b1, b2;
    logic signed [ACC_W-1:0]   prod_a, prod_b;
    logic signed [ACC_W:0]     ew_sum;
    logic signed [ACC_W:0]     ew_shift;
    logic signed [DATA_W-1:0]  ew_val;
    logic                      ew_ovf;
    logic signed [ACC_W-1:0]   add_val, fin_val, alpha_ext;
    logic                      add_ovf, fin_ovf;
    logic                      is_red_mode;
    logic [DATA_W-1:0]         root;
    logic                      sqrt_busy;
    logic                      out_free;

    function automatic logic [ACC_W:0] sat_add(logic signed [ACC_W-1:0] a,
                                               logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
        end
        return {1'b0, s[ACC_W-1:0]};
    endfunction

    assign is_red_mode = (mode_reg <= MODE_NORM);
    assign out_free    = !out_valid_reg || out_ready;

    // multiplier operand select
    always_comb
    begin
        a1 = '0;
        a2 = '0;
        b1 = '0;
        b2 = '0;
        unique case (mode_reg)
            MODE_DOT, MODE_DOT_ALPHA:
            begin
                a1 = x_reg;
                a2 = y_reg;
            end
            MODE_ABS_SUM:
            begin
                a1 = x_reg;
                a2 = x_reg[DATA_W-1] ? -SCALE : SCALE;
            end
            MODE_NORM:
            begin
                a1 = x_reg;
                a2 = x_reg;
            end
            MODE_AXPY:
            begin
                a1 = alpha_reg;
                a2 = x_reg;
                b1 = y_reg;
                b2 = SCALE;
            end
            MODE_ROTATE:
            begin
                a1 = cos_reg;
                b1 = sin_reg;
                a2 = cmd.phase ? y_reg : x_reg;
                b2 = cmd.phase ? x_reg : y_reg;
            end
            default:
            begin
                a1 = '0;
            end
        endcase
    end

    assign prod_a = a1 * a2;
    assign prod_b = b1 * b2;

    // elementwise floor and clip
    assign ew_sum   = (mode_reg == MODE_ROTATE && cmd.phase)
                    ? ({prod_a_reg[ACC_W-1], prod_a_reg} - {prod_b_reg[ACC_W-1], prod_b_reg})
                    : ({prod_a_reg[ACC_W-1], prod_a_reg} + {prod_b_reg[ACC_W-1], prod_b_reg});
    assign ew_shift = ew_sum >>> FRAC_BITS;
    assign ew_ovf   = !((&ew_shift[ACC_W:DATA_W-1]) || !(|ew_shift[ACC_W:DATA_W-1]));
    assign ew_val   = ew_ovf ? {ew_shift[ACC_W], {(DATA_W-1){~ew_shift[ACC_W]}}}
                             : ew_shift[DATA_W-1:0];

    assign {add_ovf, add_val} = sat_add(acc_reg, prod_a_reg);
    assign alpha_ext          = ACC_W'(signed'(alpha_reg)) <<< FRAC_BITS;
    assign {fin_ovf, fin_val} = sat_add(acc_reg, alpha_ext);

    blas_l1_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sqrt_start),
        .operand (acc_reg[ACC_W-1] ? '0 : acc_reg),
        .busy    (sqrt_busy),
        .root    (root)
    );

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DOT;
            alpha_reg     <= ALPHA_RST;
            cos_reg       <= ROT_COS_RST;
            sin_reg       <= ROT_SIN_RST;
            acc_reg       <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:    mode_reg  <= cfg_data[MODE_W-1:0];
                    REG_ALPHA:   alpha_reg <= cfg_data;
                    REG_ROT_COS: cos_reg   <= cfg_data;
                    REG_ROT_SIN: sin_reg   <= cfg_data;
                    default:     mode_reg  <= mode_reg;
                endcase
            end
            if (cmd.add && is_red_mode)
            begin
                acc_reg    <= add_val;
                sticky_reg <= sticky_reg | add_ovf;
            end
            else if (cmd.fin)
            begin
                acc_reg    <= '0;
                sticky_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= x_value;
            y_reg    <= y_value;
            last_reg <= last;
        end
        if (cmd.mul)
        begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
        end
        if (cmd.add && !is_red_mode)
        begin
            sum_reg <= '0;
            if (mode_reg == MODE_ROTATE && !cmd.phase)
            begin
                xo_reg  <= ew_val;
                sat_reg <= ew_ovf;
            end
            else if (mode_reg == MODE_ROTATE)
            begin
                yo_reg  <= ew_val;
                sat_reg <= sat_reg | ew_ovf;
            end
            else
            begin
                xo_reg  <= '0;
                yo_reg  <= ew_val;
                sat_reg <= ew_ovf;
            end
        end
        if (cmd.fin)
        begin
            xo_reg <= '0;
            yo_reg <= '0;
            if (mode_reg == MODE_DOT_ALPHA)
            begin
                sum_reg <= fin_val;
                sat_reg <= sticky_reg | fin_ovf;
            end
            else
            begin
                sum_reg <= acc_reg;
                sat_reg <= sticky_reg;
            end
        end
        if (cmd.root_load)
        begin
            sum_reg <= ACC_W'(root);
        end
        if (cmd.push)
        begin
            xo_out_reg  <= xo_reg;
            yo_out_reg  <= yo_reg;
            sum_out_reg <= sum_reg;
            red_out_reg <= is_red_mode;
            sat_out_reg <= sat_reg;
        end
    end

    assign sts.in_valid  = in_valid;
    assign sts.last      = last_reg;
    assign sts.mode      = mode_reg;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.out_free  = out_free;

    assign out_valid    = out_valid_reg;
    assign x_out        = xo_out_reg;
    assign y_out        = yo_out_reg;
    assign sum_out      = sum_out_reg;
    assign is_reduction = red_out_reg;
    assign saturated    = sat_out_reg;

endmodule

// ===== rtl/blas_l1_ctrl.sv =====
// ----------------------------------------------------------------------------
// blas_l1_ctrl
// controller sequencing multiply, add, finish, square root and output
// ----------------------------------------------------------------------------
`include "blas_level1_vector_unit_top_assert.svh"

module blas_l1_ctrl
    import blas_l1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd,
    output logic       in_ready
);

    ctrl_state_t state_reg, state_next;
    logic        phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                phase_next = 1'b0;
                if (sts.in_valid && sts.mode <= MODE_ROTATE)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                priority if (sts.mode <= MODE_NORM)
                begin
                    state_next = sts.last ? S_FIN : S_IDLE;
                end
                else if (sts.mode == MODE_ROTATE && !phase_reg)
                begin
                    state_next = S_MUL;
                    phase_next = 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_FIN:
            begin
                state_next = (sts.mode == MODE_NORM) ? S_SQRT : S_OUT;
            end
            S_SQRT:
            begin
                if (!sts.sqrt_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.phase      = phase_reg;
        cmd.load       = (state_reg == S_IDLE) && sts.in_valid;
        cmd.mul        = (state_reg == S_MUL);
        cmd.add        = (state_reg == S_ADD);
        cmd.fin        = (state_reg == S_FIN);
        cmd.sqrt_start = (state_reg == S_FIN) && (sts.mode == MODE_NORM);
        cmd.root_load  = (state_reg == S_SQRT) && !sts.sqrt_busy;
        cmd.push       = (state_reg == S_OUT) && sts.out_free;
        in_ready       = (state_reg == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    `BL1_ASSERT_IMP(a_push_free, clk, rst_n, cmd.push, sts.out_free, "push while result held")
    `BL1_ASSERT_IMP(a_sqrt_norm, clk, rst_n, state_reg == S_SQRT, sts.mode == MODE_NORM, "root outside norm")
    `BL1_ASSERT_NXT(a_load_mul, clk, rst_n, cmd.load && sts.mode <= MODE_ROTATE, state_reg == S_MUL, "item not started")
    `BL1_ASSERT_IMP(a_phase_rot, clk, rst_n, phase_reg && state_reg != S_IDLE, sts.mode == MODE_ROTATE, "second pass outside rotate")

endmodule

// ===== bench/blas_level1_vector_unit_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blas_level1_vector_unit_top_tb
// self-checking bench for the fixed-point level-1 vector unit: a scoreboard
// predicts every reduction and elementwise result from the accepted items and
// the mirrored registers; directed corner cases come first, then random
// vectors under random settings with sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module blas_level1_vector_unit_top_tb;
    import blas_l1_pkg::*;

    localparam logic [MODE_W-1:0]        MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0]        MODE_UNUSED_7 = 3'd7;
    localparam logic signed [DATA_W-1:0] DATA_MAX      = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] DATA_MIN      = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]  ACC_MAX       = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [ACC_W-1:0]  ACC_MIN       = 64'sh8000_0000_0000_0000;
    localparam int                       SETTLE_CYCLES = 60;
    localparam int                       HANG_LIMIT    = 4000;
    localparam int                       RANDOM_ITEMS  = 450;

    typedef struct {
        logic [DATA_W-1:0] x_out;
        logic [DATA_W-1:0] y_out;
        logic [ACC_W-1:0]  sum_out;
        logic              is_reduction;
        logic              saturated;
    } vec_result_t;

    class vec_unit_scoreboard;
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] alpha;
        logic signed [DATA_W-1:0] rot_cos;
        logic signed [DATA_W-1:0] rot_sin;
        logic signed [ACC_W-1:0]  acc;
        bit                       sticky;
        vec_result_t              pending_outputs[$];
        int                       mismatch_count;

        function new();
            mode           = MODE_DOT;
            alpha          = ALPHA_RST;
            rot_cos        = ROT_COS_RST;
            rot_sin        = ROT_SIN_RST;
            acc            = '0;
            sticky         = 1'b0;
            mismatch_count = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        function void write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
            case (idx)
                REG_MODE:    mode    = val[MODE_W-1:0];
                REG_ALPHA:   alpha   = val;
                REG_ROT_COS: rot_cos = val;
                REG_ROT_SIN: rot_sin = val;
                default: ;
            endcase
        endfunction

        function logic signed [ACC_W-1:0] sat_accumulate(input logic signed [ACC_W-1:0] base,
                                                         input logic signed [65:0] addend);
            logic signed [65:0] total;
            total = base + addend;
            if (total > ACC_MAX)
            begin
                sticky = 1'b1;
                return ACC_MAX;
            end
            if (total < ACC_MIN)
            begin
                sticky = 1'b1;
                return ACC_MIN;
            end
            return total[ACC_W-1:0];
        endfunction

        function logic signed [DATA_W-1:0] floor_clip(input logic signed [65:0] v,
                                                      inout bit clipped);
            logic signed [65:0] shifted;
            shifted = v >>> FRAC_BITS;
            if (shifted > DATA_MAX)
            begin
                clipped = 1'b1;
                return DATA_MAX;
            end
            if (shifted < DATA_MIN)
            begin
                clipped = 1'b1;
                return DATA_MIN;
            end
            return shifted[DATA_W-1:0];
        endfunction

        function logic [ACC_W-1:0] int_sqrt(input logic [ACC_W-1:0] v);
            logic [ACC_W-1:0] root;
            logic [ACC_W-1:0] trial;
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        // expected output of one accepted element, if it causes one
        function void compute_blas_result(input logic signed [DATA_W-1:0] x,
                                          input logic signed [DATA_W-1:0] y,
                                          input logic last);
            logic signed [65:0] xw;
            logic signed [65:0] yw;
            logic signed [65:0] aw;
            logic signed [65:0] cw;
            logic signed [65:0] sw;
            logic signed [65:0] term;
            logic signed [ACC_W-1:0] sum;
            vec_result_t res;
            bit clipped;
            xw      = x;
            yw      = y;
            aw      = alpha;
            cw      = rot_cos;
            sw      = rot_sin;
            clipped = 1'b0;
            res     = '{default: '0};
            case (mode)
                MODE_DOT, MODE_DOT_ALPHA, MODE_ABS_SUM, MODE_NORM:
                begin
                    if (mode == MODE_ABS_SUM)
                        term = (xw < 0 ? -xw : xw) <<< FRAC_BITS;
                    else if (mode == MODE_NORM)
                        term = xw * xw;
                    else
                        term = xw * yw;
                    acc = sat_accumulate(acc, term);
                    if (last)
                    begin
                        sum = acc;
                        if (mode == MODE_DOT_ALPHA)
                            sum = sat_accumulate(sum, aw <<< FRAC_BITS);
                        else if (mode == MODE_NORM)
                            sum = int_sqrt(sum < 0 ? 64'd0 : sum);
                        res.sum_out      = sum;
                        res.is_reduction = 1'b1;
                        res.saturated    = sticky;
                        acc              = '0;
                        sticky           = 1'b0;
                        pending_outputs.push_back(res);
                    end
                end
                MODE_AXPY:
                begin
                    res.y_out     = floor_clip(aw * xw + (yw <<< FRAC_BITS), clipped);
                    res.saturated = clipped;
                    pending_outputs.push_back(res);
                end
                MODE_ROTATE:
                begin
                    res.x_out     = floor_clip(cw * xw + sw * yw, clipped);
                    res.y_out     = floor_clip(cw * yw - sw * xw, clipped);
                    res.saturated = clipped;
                    pending_outputs.push_back(res);
                end
                default: ;
            endcase
        endfunction

        task compare_field(input string name, input logic [ACC_W-1:0] got,
                           input logic [ACC_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_output(input logic [127:0] tdata, input logic [1:0] tuser);
            vec_result_t want;
            if (pending_outputs.size() == 0)
            begin
                report($sformatf("unexpected result tdata %h tuser %b", tdata, tuser));
                return;
            end
            want = pending_outputs.pop_front();
            compare_field("x_out", tdata[31:0], want.x_out);
            compare_field("y_out", tdata[63:32], want.y_out);
            compare_field("sum_out", tdata[127:64], want.sum_out);
            compare_field("is_reduction", tuser[0], want.is_reduction);
            compare_field("saturated", tuser[1], want.saturated);
        endtask
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [IDX_W-1:0]    cfg_index     = '0;
    logic [DATA_W-1:0]   cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata  = '0;   // x_value, y_value
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [127:0]        m_axis_tdata;         // x_out, y_out, sum_out
    logic [1:0]          m_axis_tuser;         // is_reduction, saturated

    vec_unit_scoreboard sb;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    int                 idle_cycles   = 0;

    blas_level1_vector_unit_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.compute_blas_result(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= HANG_LIMIT)
        begin
            $display("blas_level1_vector_unit_top_tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // hold off until every expected result is out and the block has gone quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3, 4, 5: return DATA_W'($signed($urandom_range(32'h8_0000)) - 32'sh4_0000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned  sent;
        int unsigned  phase;
        int unsigned  vec_len;
        logic [MODE_W-1:0] cur_mode;
        logic         last;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain dot, single element and both saturation directions
        send_item(32'h0001_0000, 32'hfffd_0000, 1'b1);
        send_item(DATA_MAX, DATA_MAX, 1'b0);
        send_item(DATA_MIN, DATA_MIN, 1'b0);
        send_item(DATA_MIN, DATA_MIN, 1'b1);
        send_item(DATA_MIN, DATA_MAX, 1'b0);
        send_item(DATA_MIN, DATA_MAX, 1'b0);
        send_item(DATA_MIN, DATA_MAX, 1'b1);
        // open vector carried into abs sum across a mode change
        send_item(32'h0003_0000, 32'h0002_0000, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_ABS_SUM));
        send_item(32'hfffb_0000, 32'h1234_5678, 1'b1);
        send_item(DATA_MIN, DATA_MAX, 1'b1);
        drain();
        write_reg(REG_MODE, 32'(MODE_DOT_ALPHA));
        write_reg(REG_ALPHA, DATA_MAX);
        send_item(DATA_MAX, DATA_MAX, 1'b0);
        send_item(DATA_MAX, DATA_MAX, 1'b1);
        drain();
        write_reg(REG_ALPHA, DATA_MIN);
        send_item('0, '0, 1'b1);
        drain();
        write_reg(REG_MODE, 32'(MODE_NORM));
        send_item(DATA_MIN, 32'h5555_aaaa, 1'b1);
        send_item(DATA_MIN, '0, 1'b0);
        send_item(DATA_MIN, '0, 1'b1);
        send_item('0, '0, 1'b1);
        drain();
        write_reg(REG_MODE, 32'(MODE_AXPY));
        send_item(DATA_MAX, DATA_MAX, 1'b0);
        send_item(DATA_MIN, DATA_MIN, 1'b1);
        drain();
        write_reg(REG_ALPHA, 32'h0000_8000);
        send_item(32'd3, '0, 1'b0);
        send_item(32'hffff_fffd, '0, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_ROTATE));
        write_reg(REG_ROT_COS, DATA_MIN);
        write_reg(REG_ROT_SIN, DATA_MIN);
        send_item(DATA_MIN, DATA_MIN, 1'b0);
        send_item(DATA_MAX, DATA_MIN, 1'b1);
        drain();
        // unused mode codes drop the item
        write_reg(REG_MODE, 32'(MODE_UNUSED_6));
        send_item(32'd1, 32'd2, 1'b1);
        drain();
        write_reg(REG_MODE, {29'h1fff_ffff, MODE_UNUSED_7});
        send_item(32'd3, 32'd4, 1'b0);
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            if ($urandom_range(15) == 0)
                cur_mode = $urandom_range(1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
            else
                cur_mode = MODE_W'($urandom_range(5));
            write_reg(REG_MODE, {29'($urandom), cur_mode});
            write_reg(REG_ALPHA, rand_word());
            write_reg(REG_ROT_COS, rand_word());
            write_reg(REG_ROT_SIN, rand_word());
            repeat ($urandom_range(2, 5))
            begin
                vec_len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
                for (int i = 0; i < vec_len; i++)
                begin
                    last = (i == vec_len - 1);
                    if ($urandom_range(19) == 0)
                        last = ~last;
                    send_item(rand_word(), rand_word(), last);
                    if (cur_mode != MODE_UNUSED_6 && cur_mode != MODE_UNUSED_7)
                        sent++;
                end
            end
            drain();
            phase++;
        end

        if (sb.mismatch_count == 0 && sb.pending_outputs.size() == 0)
            $display("blas_level1_vector_unit_top_tb passed");
        else
            $display("blas_level1_vector_unit_top_tb failed");
        $finish;
    end

endmodule
